[src/csse_pkg.sv]
// ---------------------------------------------------------------------------
// csse_pkg: shared types and constants for the container stack state engine
// Operation and status codes, word structs and the front-to-back command.
// ---------------------------------------------------------------------------
package csse_pkg;

  localparam int MaxStacksDef = 16;
  localparam int MaxTiersDef  = 16;
  localparam int PrioBitsDef  = 8;

  typedef enum logic [1:0] {
    FN_CLEAR    = 2'd0,
    FN_LOAD     = 2'd1,
    FN_RELOCATE = 2'd2,
    FN_RETRIEVE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SRC_EMPTY = 3'd1,
    ST_DST_FULL  = 3'd2,
    ST_NO_BLOCKS = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_STACKS   = 2'd0,
    CFG_TIERS    = 2'd1,
    CFG_GROUND   = 2'd2,
    CFG_TRACKING = 2'd3
  } cfg_idx_t;

  // change kinds for tracking
  typedef enum logic [1:0] {
    CK_NEVER    = 2'd0,
    CK_OUT      = 2'd1,
    CK_IN       = 2'd2,
    CK_RETRIEVE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  src_stack;
    logic [3:0]  dst_stack;
    logic [7:0]  priority_req;
    logic [15:0] time_label;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] acted_stack;
    logic [7:0] moved_priority;
    logic [3:0] best_stack;
    logic       retrievable;
    logic       empty_stack_exists;
    logic [8:0] blocks_left;
    logic [8:0] bad_count;
  } out_word_t;

  // classified command, front to back
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  src_stack;
    logic [3:0]  dst_stack;
    logic [7:0]  priority_req;
    logic [15:0] time_label;
    logic        bad_index;
  } cmd_t;

endpackage

[src/csse_front.sv]
// ---------------------------------------------------------------------------
// csse_front: command intake
// Accepts input words, flags out-of-range stack indexes and queues them in a
// short FIFO toward the execution engine.
// ---------------------------------------------------------------------------
module csse_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               flush,
  input  logic [4:0]         stacks_used,
  input  logic               in_valid,
  output logic               in_ready,
  input  csse_pkg::in_word_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output csse_pkg::cmd_t     cmd_data
);
  import csse_pkg::*;

  localparam int Depth = 2;

  cmd_t       fifo [Depth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push, pop;

  // classify: bad index depends on operation
  always_comb begin
    cmd_in.func         = in_data.func;
    cmd_in.src_stack    = in_data.src_stack;
    cmd_in.dst_stack    = in_data.dst_stack;
    cmd_in.priority_req = in_data.priority_req;
    cmd_in.time_label   = in_data.time_label;
    case (in_data.func)
      FN_LOAD:     cmd_in.bad_index = {1'b0, in_data.dst_stack} >= stacks_used;
      FN_RELOCATE: cmd_in.bad_index = ({1'b0, in_data.dst_stack} >= stacks_used) ||
                                      ({1'b0, in_data.src_stack} >= stacks_used);
      default:     cmd_in.bad_index = 1'b0;
    endcase
  end

  assign in_ready  = (count != 2'(Depth)) && !flush;
  assign push      = in_valid && in_ready;
  assign cmd_valid = count != 2'd0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_data  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[src/csse_back.sv]
// ---------------------------------------------------------------------------
// csse_back: execution engine
// Carries out one command: slot memory access, stack push/pop, then shifts
// the changed stack through the sorted order one neighbour per cycle and
// finally registers the result word.
// ---------------------------------------------------------------------------
module csse_back #(
  parameter int MAX_STACKS = csse_pkg::MaxStacksDef,
  parameter int MAX_TIERS  = csse_pkg::MaxTiersDef,
  parameter int PRIO_BITS  = csse_pkg::PrioBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_clear,
  input  logic [4:0]          stacks_used,
  input  logic [4:0]          tiers_used,
  input  logic [8:0]          ground_priority,
  input  logic                tracking_on,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  csse_pkg::cmd_t      cmd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csse_pkg::out_word_t out_data,
  output logic                busy
);
  import csse_pkg::*;

  localparam int SW    = $clog2(MAX_STACKS);
  localparam int TW    = $clog2(MAX_TIERS + 1);
  localparam int Row   = MAX_TIERS + 1;
  localparam int Slots = MAX_STACKS * Row;
  localparam int AW    = $clog2(Slots);
  localparam int DW    = $clog2(MAX_TIERS + 1);

  typedef enum logic [3:0] {
    BS_IDLE, BS_CLEAR, BS_RD_SRC, BS_POP, BS_POP_KEY, BS_RD_DST, BS_PUSH,
    BS_SHIFT, BS_DONE, BS_OUT
  } bstate_t;

  bstate_t state, state_next;

  // slot memory: priority, min, depth, label
  logic [8:0]  mem_prio  [Slots];
  logic [8:0]  mem_min   [Slots];
  logic [DW-1:0] mem_dep [Slots];
  logic [15:0] mem_label [Slots];
  logic [AW-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [8:0]  wr_prio, wr_min;
  logic [DW-1:0] wr_dep;
  logic [8:0]  rd_prio, rd_min;
  logic [DW-1:0] rd_dep;

  // per stack state (top key cached in registers)
  logic [TW-1:0] height [MAX_STACKS];
  logic [8:0]    top_min [MAX_STACKS];
  logic [DW-1:0] top_dep [MAX_STACKS];
  logic [SW-1:0] order  [MAX_STACKS];
  logic [SW-1:0] rank   [MAX_STACKS];
  logic [15:0]   change_time [MAX_STACKS];
  logic [1:0]    change_kind [MAX_STACKS];
  logic [15:0]   out_time [MAX_STACKS];
  logic [15:0]   in_time  [MAX_STACKS];

  logic [8:0] block_count, misplaced_count;
  cmd_t        cmd;
  cmd_t        cmd_pick;
  logic [2:0]  status;
  logic [2:0]  chk_status;
  logic [SW-1:0] acted, cur, nb;
  logic [7:0]  moved;
  logic [8:0]  mv_prio;
  logic        dir_back;
  logic        relocate_push;

  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
                                               input logic [TW-1:0] h);
    slot_addr = AW'(32'(s) * Row + 32'(h));
  endfunction

  // memory: one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_prio[wr_addr]  <= wr_prio;
      mem_min[wr_addr]   <= wr_min;
      mem_dep[wr_addr]   <= wr_dep;
    end
    if (wr_en && tracking_on) mem_label[wr_addr] <= cmd.time_label;
    rd_prio <= mem_prio[rd_addr];
    rd_min  <= mem_min[rd_addr];
    rd_dep  <= mem_dep[rd_addr];
  end

  // neighbour compare for the shift
  logic [SW-1:0] pos;
  logic          can_move;
  logic [SW-1:0] npos;
  logic          less_than, greater_than;
  always_comb begin
    pos  = rank[cur];
    npos = dir_back ? pos + 1'b1 : pos - 1'b1;
    nb   = order[npos];
    less_than = (top_min[cur] < top_min[nb]) ||
                ((top_min[cur] == top_min[nb]) && (top_dep[cur] < top_dep[nb]));
    greater_than = (top_min[cur] > top_min[nb]) ||
                   ((top_min[cur] == top_min[nb]) && (top_dep[cur] > top_dep[nb]));
    if (dir_back)
      can_move = ({1'b0, pos} + 1'b1 < (SW+1)'(stacks_used)) && greater_than;
    else
      can_move = (pos != '0) && less_than;
  end

  logic [SW-1:0] cur_s;
  logic [TW-1:0] cur_h;
  always_comb begin
    cur_s = relocate_push ? cmd.dst_stack[SW-1:0] : cmd.src_stack[SW-1:0];
    cur_h = height[cur_s];
  end

  // next state and memory control; a push builds on the cached top key
  logic [8:0]    new_min;
  logic [DW-1:0] new_dep;
  always_comb begin
    state_next = state;
    rd_addr = slot_addr(cur_s, cur_h);
    wr_en   = 1'b0;
    wr_addr = slot_addr(cur_s, cur_h + 1'b1);
    wr_prio = mv_prio;
    wr_min  = ground_priority;
    wr_dep  = '0;
    if (mv_prio <= top_min[cur_s]) begin
      new_min = mv_prio;
      new_dep = '0;
    end else begin
      new_min = top_min[cur_s];
      new_dep = top_dep[cur_s] + 1'b1;
    end
    case (state)
      BS_IDLE:
        if (cmd_valid) state_next = (cmd_data.func == FN_CLEAR) ? BS_CLEAR : BS_RD_SRC;
      BS_CLEAR: state_next = BS_DONE;
      BS_RD_SRC: begin
        state_next = BS_DONE;
        if (cmd.func == FN_RETRIEVE || cmd.func == FN_RELOCATE) state_next = BS_POP;
        else if (cmd.func == FN_LOAD) state_next = BS_PUSH;
        if (chk_status != ST_OK) state_next = BS_DONE;
      end
      BS_POP: begin
        // fetch the slot below, which becomes the new top
        rd_addr    = slot_addr(cur_s, cur_h - 1'b1);
        state_next = BS_POP_KEY;
      end
      BS_POP_KEY: state_next = BS_SHIFT;
      BS_RD_DST: state_next = BS_PUSH;
      BS_PUSH: begin
        wr_en   = 1'b1;
        wr_min  = new_min;
        wr_dep  = new_dep;
        state_next = BS_SHIFT;
      end
      BS_SHIFT:
        if (!can_move)
          state_next = (cmd.func == FN_RELOCATE && !relocate_push) ? BS_RD_DST : BS_DONE;
      BS_DONE: state_next = BS_OUT;
      BS_OUT:  if (out_ready) state_next = BS_IDLE;
      default: state_next = BS_IDLE;
    endcase
  end

  assign cmd_ready = (state == BS_IDLE);
  assign out_valid = (state == BS_OUT);
  assign busy      = (state != BS_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= BS_IDLE;
    else     state <= state_next;
  end

  logic [SW-1:0] best;
  assign best = order[0];

  // retrieve always works on the current best stack
  always_comb begin
    cmd_pick = cmd_data;
    if (cmd_data.func == FN_RETRIEVE) cmd_pick.src_stack = 4'(best);
  end

  // refusal checks on the latched command
  always_comb begin
    chk_status = ST_OK;
    case (cmd.func)
      FN_LOAD:
        if (cmd.bad_index) chk_status = ST_BAD_INDEX;
        else if ({1'b0, height[cmd.dst_stack[SW-1:0]]} >= (TW+1)'(tiers_used))
          chk_status = ST_DST_FULL;
      FN_RELOCATE:
        if (cmd.bad_index) chk_status = ST_BAD_INDEX;
        else if (height[cmd.src_stack[SW-1:0]] == '0) chk_status = ST_SRC_EMPTY;
        else if ({1'b0, height[cmd.dst_stack[SW-1:0]]} >= (TW+1)'(tiers_used))
          chk_status = ST_DST_FULL;
      FN_RETRIEVE:
        if (block_count == '0 || height[best] == '0) chk_status = ST_NO_BLOCKS;
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      for (int i = 0; i < MAX_STACKS; i++) begin
        height[i]  <= '0;
        top_min[i] <= ground_priority;
        top_dep[i] <= '0;
        order[i]   <= SW'(i);
        rank[i]    <= SW'(i);
        change_time[i] <= '0;
        change_kind[i] <= CK_NEVER;
        out_time[i] <= '0;
        in_time[i]  <= '0;
      end
      block_count     <= '0;
      misplaced_count <= '0;
    end else begin
      case (state)
        BS_IDLE:
          if (cmd_valid) begin
            cmd <= cmd_pick;
            relocate_push <= (cmd_data.func == FN_LOAD);
            status <= ST_OK;
            acted  <= '0;
            moved  <= '0;
          end
        BS_CLEAR: begin
          for (int i = 0; i < MAX_STACKS; i++) begin
            height[i]  <= '0;
            top_min[i] <= ground_priority;
            top_dep[i] <= '0;
            order[i]   <= SW'(i);
            rank[i]    <= SW'(i);
            change_time[i] <= '0;
            change_kind[i] <= CK_NEVER;
            out_time[i] <= '0;
            in_time[i]  <= '0;
          end
          block_count     <= '0;
          misplaced_count <= '0;
        end
        BS_RD_SRC: begin
          // checks; the memory read of the top slot is in flight
          mv_prio <= {1'b0, cmd.priority_req & 8'((1 << PRIO_BITS) - 1)};
          status  <= chk_status;
          cur     <= cur_s;
        end
        BS_POP: begin
          // top slot data now valid in rd_*; read the slot below next
          mv_prio <= rd_prio;
          moved   <= rd_prio[7:0];
          height[cur] <= height[cur] - 1'b1;
          dir_back <= (rd_dep == '0);
          if (rd_dep != '0) misplaced_count <= misplaced_count - 1'b1;
          if (cmd.func == FN_RETRIEVE) begin
            block_count <= block_count - 1'b1;
            acted <= cur;
            if (tracking_on) begin
              change_time[cur] <= cmd.time_label;
              change_kind[cur] <= CK_RETRIEVE;
            end
          end else if (tracking_on) begin
            change_time[cur] <= cmd.time_label;
            change_kind[cur] <= CK_OUT;
            out_time[cur]    <= cmd.time_label;
          end
        end
        BS_POP_KEY: begin
          // new top key; an emptied stack takes the ground key, not the floor slot data
          top_min[cur] <= (height[cur] == '0) ? ground_priority : rd_min;
          top_dep[cur] <= (height[cur] == '0) ? '0 : rd_dep;
        end
        BS_RD_DST: begin
          relocate_push <= 1'b1;
        end
        BS_PUSH: begin
          cur <= cur_s;
          height[cur_s]  <= cur_h + 1'b1;
          top_min[cur_s] <= new_min;
          top_dep[cur_s] <= new_dep;
          dir_back <= (new_dep != '0);
          if (new_dep != '0) misplaced_count <= misplaced_count + 1'b1;
          if (cmd.func == FN_LOAD) begin
            block_count <= block_count + 1'b1;
            moved <= mv_prio[7:0];
          end
          acted <= cur_s;
          if (tracking_on) begin
            change_time[cur_s] <= cmd.time_label;
            change_kind[cur_s] <= CK_IN;
            in_time[cur_s]     <= cmd.time_label;
          end
        end
        BS_SHIFT: begin
          if (can_move) begin
            order[pos]  <= nb;
            rank[nb]    <= pos;
            order[npos] <= cur;
            rank[cur]   <= npos;
          end
        end
        default: ;
      endcase
    end
  end

  // result word
  always_comb begin
    out_data.status             = status;
    out_data.acted_stack        = (status == ST_OK) ? 4'(acted) : 4'd0;
    out_data.moved_priority     = (status == ST_OK) ? moved : 8'd0;
    out_data.best_stack         = 4'(best);
    out_data.retrievable        = (block_count != '0) && (top_dep[best] == '0);
    out_data.empty_stack_exists = height[order[SW'(stacks_used - 5'd1)]] == '0;
    out_data.blocks_left        = block_count;
    out_data.bad_count          = misplaced_count;
  end

endmodule

[src/container_stack_state_engine_unit.sv]
// ---------------------------------------------------------------------------
// container_stack_state_engine_unit: bounded prioritized stack engine
// Intake queue in front of an execution engine holding the stacks.
// ---------------------------------------------------------------------------
// One result word per input word, handled one at a time. Each word waits in
// the intake queue, then the engine carries it out: a clear resets every stack,
// a refused word goes straight to its result, and any other word pops or pushes
// and then moves the changed stack through the sorted order one neighbour at a
// time (relocate moves two stacks) before its result is offered. A stalled
// result holds the engine.
module container_stack_state_engine_unit #(
  parameter int MAX_STACKS = csse_pkg::MaxStacksDef,
  parameter int MAX_TIERS  = csse_pkg::MaxTiersDef,
  parameter int PRIO_BITS  = csse_pkg::PrioBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  csse_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csse_pkg::out_word_t out_data
);
  import csse_pkg::*;

  logic [4:0] stacks_used, tiers_used;
  logic [8:0] ground_priority;
  logic [8:0] ground_eff;
  logic       tracking_on;
  logic       cfg_clear;
  logic       cmd_valid, cmd_ready, busy;
  cmd_t       cmd_data;

  function automatic logic [4:0] sat(input logic [4:0] v, input int hi);
    if (v == 5'd0) sat = 5'd1;
    else if (32'(v) > hi) sat = 5'(hi);
    else sat = v;
  endfunction

  // configuration registers
  assign cfg_clear = cfg_we && (cfg_index != CFG_TRACKING);
  always_ff @(posedge clk) begin
    if (rst) begin
      stacks_used     <= 5'(MAX_STACKS);
      tiers_used      <= 5'(MAX_TIERS);
      ground_priority <= 9'd256;
      tracking_on     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STACKS:   stacks_used     <= sat(cfg_data[4:0], MAX_STACKS);
        CFG_TIERS:    tiers_used      <= sat(cfg_data[4:0], MAX_TIERS);
        CFG_GROUND:   ground_priority <= cfg_data;
        CFG_TRACKING: tracking_on     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // floor key seen by the engine, including a ground write in progress
  assign ground_eff = rst ? 9'd256 :
                      (cfg_we && cfg_index == CFG_GROUND) ? cfg_data : ground_priority;

  csse_front u_front (
    .clk, .rst, .flush(1'b0), .stacks_used,
    .in_valid, .in_ready, .in_data,
    .cmd_valid, .cmd_ready, .cmd_data
  );

  csse_back #(
    .MAX_STACKS(MAX_STACKS), .MAX_TIERS(MAX_TIERS), .PRIO_BITS(PRIO_BITS)
  ) u_back (
    .clk, .rst, .cfg_clear, .stacks_used, .tiers_used, .ground_priority(ground_eff),
    .tracking_on, .cmd_valid, .cmd_ready, .cmd_data,
    .out_valid, .out_ready, .out_data, .busy
  );

  // counts stay in range
  a_bad_le_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.bad_count <= out_data.blocks_left)
    else $error("misplaced count exceeds block count");
  // status code is one of the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_BAD_INDEX)
    else $error("status out of range");
  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // configuration only lands on an idle block
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !busy && !cmd_valid)
    else $error("configuration written with words in flight");

endmodule
